// ===== design/interrupt_load_balancer_defines.svh =====
// Assertion macros shared by the interrupt load balancer RTL.
`ifndef INTERRUPT_LOAD_BALANCER_DEFINES_SVH
`define INTERRUPT_LOAD_BALANCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ILB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ilb_pkg.sv =====
// Shared types and constants of the interrupt load balancer.
package ilb_pkg;

    localparam int DEF_MAX_CORES = 16;
    localparam int DEF_IRQ_LINES = 16;

    localparam logic [63:0] COUNT_ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] COUNT_NEAR_OVERFLOW = 64'hFFFF_FFFF_FFFF_FFFE;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC_IO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCING      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CORES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_PERIOD = 2'd3;

    typedef struct packed {
        logic       func;
        logic [3:0] irq_line;
        logic [3:0] core_id;
    } ilb_in_t;

    typedef struct packed {
        logic       eoi_to_local;
        logic       route_valid;
        logic [3:0] route_core;
        logic       counts_cleared;
    } ilb_out_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } ilb_cfg_t;

endpackage

// ===== design/ilb_stream_if.sv =====
// Valid/ready channel carrying one payload beat.
interface ilb_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/interrupt_load_balancer.sv =====
// Interrupt load balancer: per-core IRQ counters with least-count rerouting.
//
// Channels: irq_in takes one serviced interrupt per beat (func, irq_line,
// core_id); eoi_out returns exactly one result beat per input beat; cfg
// writes the four control registers (index, value) and is always ready.
// Throughput: one item at a time; the next item is taken the cycle after a
// result is loaded. A count-only item passes S_READ and then S_DONE. A balance
// item adds a remainder by the period (4 bits of the count per cycle) and,
// when the count is a multiple of the period, a scan over the active cores'
// counters through the single memory read port; S_CLEAR then zeroes those
// counters when one that is not a new lowest is near overflow.
// Reset: control registers take their defaults, then a clearing pass zeroes
// the count memory, one entry a cycle, while irq_in is held not ready.
// Stall: the result sits in an output register; the next item is accepted
// meanwhile, and its result waits until the previous beat is taken.
module interrupt_load_balancer #(
    parameter int MAX_CORES = ilb_pkg::DEF_MAX_CORES,
    parameter int IRQ_LINES = ilb_pkg::DEF_IRQ_LINES
) (
    input  logic          clk,
    input  logic          rst_n,
    ilb_stream_if.sink    irq_in,
    ilb_stream_if.source  eoi_out,
    ilb_stream_if.sink    cfg
);

    `include "interrupt_load_balancer_defines.svh"

    localparam int CW         = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int LW         = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
    localparam int AW         = CW + LW;
    localparam int DEPTH      = MAX_CORES * (1 << LW);
    localparam int CNT_W      = 64;
    localparam int DIG_W      = 4;
    localparam int DIGITS     = CNT_W / DIG_W;
    localparam int DIG_CNT_W  = $clog2(DIGITS);
    localparam int PER_W      = 16;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Count memory, addressed {core, irq}
    logic [CNT_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;

    // Configuration
    logic             sym_io_reg;
    logic             bal_en_reg;
    logic [4:0]       active_cores_reg;
    logic [PER_W-1:0] period_reg;

    // Control and datapath
    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        init_addr_reg, init_addr_next;
    logic                 func_reg, func_next;
    logic [LW-1:0]        irq_reg, irq_next;
    logic [CW-1:0]        core_reg, core_next;
    logic [CW-1:0]        last_reg, last_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [PER_W-1:0]     rem_reg, rem_next;
    logic [DIG_CNT_W-1:0] dig_reg, dig_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 pend_reg, pend_next;
    logic [CW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]     min_reg, min_next;
    logic [CW-1:0]        best_reg, best_next;
    logic                 clr_reg, clr_next;
    logic                 route_valid_reg, route_valid_next;
    logic                 out_valid_reg, out_valid_next;
    ilb_pkg::ilb_out_t    out_data_reg, out_data_next;

    logic [CW-1:0]    in_core;
    logic [LW-1:0]    in_irq;
    logic             in_range;
    logic [CNT_W-1:0] cnt_inc;
    logic [PER_W:0]   mod_t;
    logic [PER_W-1:0] mod_rem;
    logic             scan_clr;

    assign in_core  = CW'(irq_in.data.core_id);
    assign in_irq   = LW'(irq_in.data.irq_line);
    assign in_range = (int'(irq_in.data.irq_line) < IRQ_LINES) &&
                      (int'(irq_in.data.core_id) < MAX_CORES);
    assign cnt_inc  = rd_data_reg + 64'd1;

    assign irq_in.ready  = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign eoi_out.valid = out_valid_reg;
    assign eoi_out.data  = out_data_reg;

    assign mem_raddr = (state_reg == S_SCAN) ? {idx_reg, irq_reg} : {in_core, in_irq};

    // One digit of the running remainder, bit by bit, MSB first
    always_comb
    begin
        mod_t   = '0;
        mod_rem = rem_reg;
        for (int b = DIG_W - 1; b >= 0; b--)
        begin
            mod_t = {mod_rem, cnt_reg[CNT_W - DIG_W + b]};
            if (mod_t >= {1'b0, period_reg})
            begin
                mod_t = mod_t - {1'b0, period_reg};
            end
            mod_rem = mod_t[PER_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next       = state_reg;
        init_addr_next   = init_addr_reg;
        func_next        = func_reg;
        irq_next         = irq_reg;
        core_next        = core_reg;
        last_next        = last_reg;
        cnt_next         = cnt_reg;
        rem_next         = rem_reg;
        dig_next         = dig_reg;
        idx_next         = idx_reg;
        issue_done_next  = issue_done_reg;
        pend_next        = pend_reg;
        cmp_idx_next     = cmp_idx_reg;
        min_next         = min_reg;
        best_next        = best_reg;
        clr_next         = clr_reg;
        route_valid_next = route_valid_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        scan_clr         = clr_reg;

        // Drop the result beat once taken
        if (eoi_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_addr_reg;
                if (init_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_addr_next = init_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (irq_in.valid)
                begin
                    func_next        = irq_in.data.func;
                    irq_next         = in_irq;
                    core_next        = in_core;
                    route_valid_next = 1'b0;
                    clr_next         = 1'b0;
                    best_next        = '0;
                    if (active_cores_reg == '0)
                    begin
                        last_next = '0;
                    end
                    else if (int'(active_cores_reg) > MAX_CORES)
                    begin
                        last_next = CW'(MAX_CORES - 1);
                    end
                    else
                    begin
                        last_next = CW'(active_cores_reg - 5'd1);
                    end
                    state_next = in_range ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                mem_we    = 1'b1;
                mem_waddr = {core_reg, irq_reg};
                mem_wdata = cnt_inc;
                cnt_next  = cnt_inc;
                rem_next  = '0;
                dig_next  = '0;
                if (func_reg && bal_en_reg && (cnt_inc != '0) && (period_reg != '0))
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                rem_next = mod_rem;
                cnt_next = cnt_reg << DIG_W;
                dig_next = dig_reg + 1'b1;
                if (dig_reg == DIG_CNT_W'(DIGITS - 1))
                begin
                    if (mod_rem == '0)
                    begin
                        idx_next        = '0;
                        issue_done_next = 1'b0;
                        pend_next       = 1'b0;
                        min_next        = ilb_pkg::COUNT_ALL_ONES;
                        best_next       = '0;
                        clr_next        = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one read a cycle, compare it the cycle after
                pend_next = !issue_done_reg;
                if (!issue_done_reg)
                begin
                    cmp_idx_next = idx_reg;
                    if (idx_reg == last_reg)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    if (rd_data_reg < min_reg)
                    begin
                        min_next  = rd_data_reg;
                        best_next = cmp_idx_reg;
                    end
                    else if (rd_data_reg >= ilb_pkg::COUNT_NEAR_OVERFLOW)
                    begin
                        scan_clr = 1'b1;
                    end
                    clr_next = scan_clr;
                    if (cmp_idx_reg == last_reg)
                    begin
                        route_valid_next = 1'b1;
                        idx_next         = '0;
                        state_next       = scan_clr ? S_CLEAR : S_DONE;
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {idx_reg, irq_reg};
                if (idx_reg == last_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || eoi_out.ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.eoi_to_local   = sym_io_reg;
                    out_data_next.route_valid    = route_valid_reg;
                    out_data_next.route_core     = 4'(best_reg);
                    out_data_next.counts_cleared = clr_reg & route_valid_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            init_addr_reg   <= '0;
            issue_done_reg  <= 1'b0;
            pend_reg        <= 1'b0;
            route_valid_reg <= 1'b0;
            clr_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            dig_reg         <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            init_addr_reg   <= init_addr_next;
            issue_done_reg  <= issue_done_next;
            pend_reg        <= pend_next;
            route_valid_reg <= route_valid_next;
            clr_reg         <= clr_next;
            out_valid_reg   <= out_valid_next;
            dig_reg         <= dig_next;
            idx_reg         <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        irq_reg      <= irq_next;
        core_reg     <= core_next;
        last_reg     <= last_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        cmp_idx_reg  <= cmp_idx_next;
        min_reg      <= min_next;
        best_reg     <= best_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_io_reg       <= 1'b0;
            bal_en_reg       <= 1'b0;
            active_cores_reg <= 5'd1;
            period_reg       <= 16'd10;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                ilb_pkg::CFG_SYMMETRIC_IO:   sym_io_reg       <= cfg.data.value[0];
                ilb_pkg::CFG_BALANCING:      bal_en_reg       <= cfg.data.value[0];
                ilb_pkg::CFG_ACTIVE_CORES:   active_cores_reg <= cfg.data.value[4:0];
                ilb_pkg::CFG_BALANCE_PERIOD: period_reg       <= cfg.data.value;
                default:                     sym_io_reg       <= sym_io_reg;
            endcase
        end
    end

    `ILB_ASSERT_SAME(a_clear_needs_route, out_valid_reg,
        !out_data_reg.counts_cleared || out_data_reg.route_valid,
        "counts cleared without a reroute")
    `ILB_ASSERT_SAME(a_mod_qualified, state_reg == S_MOD,
        func_reg && bal_en_reg && (period_reg != '0),
        "remainder step entered for an item that does not balance")
    `ILB_ASSERT_SAME(a_best_in_scan, (state_reg == S_DONE) && route_valid_reg,
        best_reg <= last_reg,
        "chosen core lies outside the active cores")
    `ILB_ASSERT_NEXT(a_result_loaded, (state_reg == S_DONE) && (!out_valid_reg || eoi_out.ready),
        out_valid_reg && (state_reg == S_IDLE),
        "finished item did not reach the output register")
    `ILB_ASSERT_SAME(a_no_stray_write,
        (state_reg == S_IDLE) || (state_reg == S_MOD) || (state_reg == S_DONE),
        !mem_we,
        "count memory written outside update and clear")

endmodule

// ===== tb/sv/ilb_checker.sv =====
// Result checker for the interrupt load balancer: watches all channels, predicts, compares.
`timescale 1ns / 100ps

module ilb_checker
    import ilb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     irq_valid,
    input  logic     irq_ready,
    input  ilb_in_t  irq_data,
    input  logic     eoi_valid,
    input  logic     eoi_ready,
    input  ilb_out_t eoi_data,
    input  logic     cfg_valid,
    input  logic     cfg_ready,
    input  ilb_cfg_t cfg_data,
    output int       mismatches,
    output int       outstanding,
    output int       reroutes
);
    localparam int MAX_CORES   = DEF_MAX_CORES;
    localparam int IRQ_LINES   = DEF_IRQ_LINES;
    localparam int PRINT_LIMIT = 40;

    logic [63:0] irq_counts [MAX_CORES][IRQ_LINES];
    logic        sym_mode;
    logic        balance_on;
    logic [4:0]  core_span_reg;
    logic [15:0] period;
    ilb_out_t    pending_eoi [$];

    int mismatch_count = 0;
    int queued         = 0;
    int reroute_count  = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = queued;
    assign reroutes    = reroute_count;

    task automatic report(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] eoi mismatch: %s", $time, what);
    endtask

    // Count one serviced interrupt and work out the result beat it should produce.
    function automatic ilb_out_t predict_eoi(input ilb_in_t item);
        ilb_out_t    r;
        logic [63:0] count;
        logic [63:0] lowest;
        int          span;
        int          best;
        bit          wipe;
        r = '0;
        r.eoi_to_local = sym_mode;
        if (int'(item.irq_line) < IRQ_LINES && int'(item.core_id) < MAX_CORES)
        begin
            count = irq_counts[item.core_id][item.irq_line] + 64'd1;
            irq_counts[item.core_id][item.irq_line] = count;
            if (item.func && balance_on && count != '0 && period != '0
                && (count % period) == '0)
            begin
                // Zero cores means one; anything past the array means all of it.
                if (core_span_reg == '0)
                    span = 1;
                else if (int'(core_span_reg) > MAX_CORES)
                    span = MAX_CORES;
                else
                    span = int'(core_span_reg);
                lowest = COUNT_ALL_ONES;
                best   = 0;
                wipe   = 1'b0;
                for (int i = 0; i < span; i++)
                begin
                    if (irq_counts[i][item.irq_line] < lowest)
                    begin
                        lowest = irq_counts[i][item.irq_line];
                        best   = i;
                    end
                    else if (irq_counts[i][item.irq_line] >= COUNT_NEAR_OVERFLOW)
                    begin
                        wipe = 1'b1;
                    end
                end
                r.route_valid = 1'b1;
                r.route_core  = 4'(best);
                if (wipe)
                begin
                    for (int i = 0; i < span; i++)
                        irq_counts[i][item.irq_line] = '0;
                    r.counts_cleared = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ilb_out_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CORES; c++)
                for (int l = 0; l < IRQ_LINES; l++)
                    irq_counts[c][l] = '0;
            sym_mode      = 1'b0;
            balance_on    = 1'b0;
            core_span_reg = 5'd1;
            period        = 16'd10;
            pending_eoi.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.index)
                    CFG_SYMMETRIC_IO:   sym_mode      = cfg_data.value[0];
                    CFG_BALANCING:      balance_on    = cfg_data.value[0];
                    CFG_ACTIVE_CORES:   core_span_reg = cfg_data.value[4:0];
                    CFG_BALANCE_PERIOD: period        = cfg_data.value;
                    default: ;
                endcase
            end
            // Check the outgoing beat before queueing a new prediction.
            if (eoi_valid && eoi_ready)
            begin
                if (pending_eoi.size() == 0)
                begin
                    report($sformatf("beat %p arrived with nothing expected", eoi_data));
                end
                else
                begin
                    want = pending_eoi.pop_front();
                    if (want.route_valid)
                        reroute_count++;
                    if (eoi_data.eoi_to_local !== want.eoi_to_local)
                        report($sformatf("eoi_to_local got %b, expected %b",
                                         eoi_data.eoi_to_local, want.eoi_to_local));
                    if (eoi_data.route_valid !== want.route_valid)
                        report($sformatf("route_valid got %b, expected %b",
                                         eoi_data.route_valid, want.route_valid));
                    if (eoi_data.route_core !== want.route_core)
                        report($sformatf("route_core got %0d, expected %0d",
                                         eoi_data.route_core, want.route_core));
                    if (eoi_data.counts_cleared !== want.counts_cleared)
                        report($sformatf("counts_cleared got %b, expected %b",
                                         eoi_data.counts_cleared, want.counts_cleared));
                end
            end
            if (irq_valid && irq_ready)
                pending_eoi.push_back(predict_eoi(irq_data));
        end
        queued = pending_eoi.size();
    end

endmodule

// ===== tb/sv/interrupt_load_balancer_test.sv =====
// Top-level testbench for the interrupt load balancer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module interrupt_load_balancer_test;
    import ilb_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 60;
    localparam int LONG_STALL    = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 54;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady        = 1'b0;
    bit   stall_request = 1'b0;
    int   mismatches;
    int   outstanding;
    int   reroutes;
    int   sent_count     = 0;
    int   settings_count = 0;

    ilb_stream_if #(.payload_t(ilb_in_t))  irq_ch ();
    ilb_stream_if #(.payload_t(ilb_out_t)) eoi_ch ();
    ilb_stream_if #(.payload_t(ilb_cfg_t)) cfg_ch ();

    interrupt_load_balancer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .irq_in  (irq_ch),
        .eoi_out (eoi_ch),
        .cfg     (cfg_ch)
    );

    ilb_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .irq_valid   (irq_ch.valid),
        .irq_ready   (irq_ch.ready),
        .irq_data    (irq_ch.data),
        .eoi_valid   (eoi_ch.valid),
        .eoi_ready   (eoi_ch.ready),
        .eoi_data    (eoi_ch.data),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_data    (cfg_ch.data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .reroutes    (reroutes)
    );

    always #(HALF_PERIOD) clk = ~clk;

    initial
    begin
        #(20_000_000);
        $display("run timed out with %0d results outstanding", outstanding);
        $display("interrupt_load_balancer_test failed");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_irq(input logic func, input logic [3:0] line,
                            input logic [3:0] core);
        ilb_in_t item;
        int      gap;
        item.func     = func;
        item.irq_line = line;
        item.core_id  = core;
        gap = pick_gap();
        if (gap > 0)
        begin
            irq_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        irq_ch.valid <= 1'b1;
        irq_ch.data  <= item;
        do @(posedge clk); while (irq_ch.ready !== 1'b1);
        sent_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: val};
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    endtask

    task automatic set_regs(input bit sym, input bit bal, input int cores, input int per);
        write_reg(CFG_SYMMETRIC_IO, CFG_DATA_W'(sym));
        write_reg(CFG_BALANCING, CFG_DATA_W'(bal));
        write_reg(CFG_ACTIVE_CORES, CFG_DATA_W'(cores));
        write_reg(CFG_BALANCE_PERIOD, CFG_DATA_W'(per));
        cfg_ch.valid <= 1'b0;
        settings_count++;
    endtask

    // Drop valid, wait for every result, then let the block go quiet.
    task automatic settle();
        irq_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : eoi_sink
        int gap;
        eoi_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                eoi_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                eoi_ch.ready <= 1'b1;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    eoi_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                eoi_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int roll;
        int cores;
        int per;
        int span;
        int line;
        int core;
        irq_ch.valid <= 1'b0;
        irq_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: balancing off, legacy EOI.
        send_irq(1'b0, 4'd0, 4'd0);
        send_irq(1'b1, 4'd15, 4'd15);
        send_irq(1'b1, 4'd0, 4'd0);
        settle();

        // Zero cores acts as one; period one rebalances on every balance beat.
        set_regs(1'b1, 1'b1, 0, 1);
        send_irq(1'b1, 4'd5, 4'd0);
        send_irq(1'b1, 4'd5, 4'd3);
        send_irq(1'b0, 4'd5, 4'd0);
        send_irq(1'b1, 4'd5, 4'd15);
        settle();

        // All sixteen cores scanned; the first lowest count wins.
        set_regs(1'b0, 1'b1, 16, 2);
        send_irq(1'b1, 4'd7, 4'd15);
        send_irq(1'b1, 4'd7, 4'd15);
        send_irq(1'b1, 4'd7, 4'd0);
        send_irq(1'b1, 4'd7, 4'd0);
        send_irq(1'b0, 4'd9, 4'd3);
        send_irq(1'b0, 4'd9, 4'd3);
        settle();

        // Zero period never triggers; oversize core count clamps.
        set_regs(1'b1, 1'b1, 31, 0);
        send_irq(1'b1, 4'd2, 4'd2);
        send_irq(1'b1, 4'd2, 4'd2);
        settle();
        set_regs(1'b0, 1'b1, 17, 65535);
        send_irq(1'b1, 4'd2, 4'd2);
        settle();

        // Balancing disabled with a period that would otherwise fire.
        set_regs(1'b1, 1'b0, 5, 3);
        send_irq(1'b1, 4'd4, 4'd1);
        send_irq(1'b1, 4'd4, 4'd1);
        send_irq(1'b1, 4'd4, 4'd1);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                cores = 0;
            else if (roll == 1)
                cores = $urandom_range(17, 31);
            else
                cores = $urandom_range(1, 16);
            if ($urandom_range(0, 7) < 6)
                per = $urandom_range(1, 6);
            else
                per = $urandom_range(0, 65535);
            set_regs(1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0, cores, per);
            span = (cores == 0) ? 1 : ((cores > DEF_MAX_CORES) ? DEF_MAX_CORES : cores);
            steady = (phase % 4 == 3);
            // Hold the result side off so the block backs up into irq_in.
            if (phase == 2)
                stall_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 5 && k == PHASE_ITEMS / 2)
                    settle();
                // Keep most beats on a few hot lines and the scanned cores.
                if ($urandom_range(0, 3) != 0)
                    line = $urandom_range(0, 2);
                else
                    line = $urandom_range(0, 15);
                if ($urandom_range(0, 4) != 0)
                    core = $urandom_range(0, span - 1);
                else
                    core = $urandom_range(0, 15);
                send_irq($urandom_range(0, 3) != 0, 4'(line), 4'(core));
            end
            settle();
        end
        steady = 1'b0;

        $display("Sent %0d serviced interrupts under %0d register settings,",
                 sent_count, settings_count);
        $display("%0d result beats carried a reroute, %0d mismatches.", reroutes, mismatches);
        if (mismatches == 0)
            $display("interrupt_load_balancer_test passed");
        else
            $display("interrupt_load_balancer_test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ilb_pkg.sv
design/ilb_stream_if.sv
design/interrupt_load_balancer.sv
tb/sv/ilb_checker.sv
tb/sv/interrupt_load_balancer_test.sv
